// ===== rtl/core/wdnr_pkg.sv =====
package wdnr_pkg;

   // Working width of the mantissa and the limb that one divide step handles.
   localparam int WIDE_BITS_DEF = 192;
   localparam int LIMB_BITS     = 32;
   localparam int IN_MANT_BITS  = 192;
   localparam int OUT_MANT_BITS = 96;

   // Decimal constants.
   localparam int           MAX_SCALE   = 28;
   localparam logic [3:0]   TEN         = 4'hA;
   localparam logic [3:0]   HALF_DIGIT  = 4'd5;
   // floor(2^35 / 10); low by less than one unit for a dividend below 10 * 2^32
   localparam logic [31:0]  RECIP_TEN   = 32'hCCCC_CCCC;
   localparam int           RECIP_SHIFT = 35;

   // Stream payload widths.
   localparam int REQ_DATA_BITS = 208;
   localparam int RSP_DATA_BITS = 104;
   localparam int RSP_USER_BITS = 2;

   // Result class codes.
   localparam logic [1:0] CLASS_NORMAL  = 2'd0;
   localparam logic [1:0] CLASS_POS_INF = 2'd1;
   localparam logic [1:0] CLASS_NEG_INF = 2'd2;

   typedef struct packed {
      logic load;       // capture a request beat
      logic div_start;  // fold the old remainder into sticky, clear the partial remainder
      logic div_step;   // divide the top limb and rotate it in at the bottom
      logic div_last;   // last limb: keep the remainder, lower the scale
      logic round;      // add the half-even increment
      logic publish;    // load the response register
   } cmd_type;

   typedef struct packed {
      logic loop_cond;  // another divide by ten is due
      logic out_full;   // response register holds an untaken beat
   } status_type;

endpackage

// ===== rtl/core/wdnr_datapath.sv =====
module wdnr_datapath
   import wdnr_pkg::*;
#(
   parameter int WIDE_BITS = WIDE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [RSP_USER_BITS-1:0] rsp_tuser
);

   localparam int LIMBS    = (WIDE_BITS + LIMB_BITS - 1) / LIMB_BITS;
   localparam int PAD_BITS = LIMBS * LIMB_BITS;
   localparam int EXT_BITS = (PAD_BITS > IN_MANT_BITS) ? PAD_BITS : IN_MANT_BITS;
   localparam logic [PAD_BITS-1:0] WIDE_MASK =
      {PAD_BITS{1'b1}} >> (PAD_BITS - WIDE_BITS);

   logic [PAD_BITS-1:0]      mant_ff, mant_in;
   logic [7:0]               scale_ff, scale_in;
   logic                     neg_ff, neg_in;
   logic [3:0]               rem_ff, rem_in;
   logic [3:0]               prem_ff, prem_in;
   logic                     sticky_ff, sticky_in;
   logic                     divided_ff, divided_in;
   logic [RSP_DATA_BITS-1:0] out_data_ff, out_data_in;
   logic [RSP_USER_BITS-1:0] out_user_ff, out_user_in;
   logic                     out_valid_ff, out_valid_in;

   logic [EXT_BITS-1:0]      in_ext;
   logic [LIMB_BITS+3:0]     cur;
   logic [LIMB_BITS+35:0]    prod;
   logic [LIMB_BITS-1:0]     q0, q;
   logic [LIMB_BITS+3:0]     r0, r;
   logic                     fix;
   logic                     upper_nz;
   logic                     round_up;

   // Divide one 36-bit chunk by ten: reciprocal estimate, then one correction.
   always_comb begin
      cur  = {prem_ff, mant_ff[PAD_BITS-1 -: LIMB_BITS]};
      prod = (LIMB_BITS + 36)'(cur) * (LIMB_BITS + 36)'(RECIP_TEN);
      q0   = prod[RECIP_SHIFT +: LIMB_BITS];
      r0   = cur - ((LIMB_BITS + 4)'({q0, 3'b000}) + (LIMB_BITS + 4)'({q0, 1'b0}));
      fix  = (r0 >= (LIMB_BITS + 4)'(TEN));
      q    = fix ? (q0 + LIMB_BITS'(1)) : q0;
      r    = fix ? (r0 - (LIMB_BITS + 4)'(TEN)) : r0;
   end

   assign upper_nz = |mant_ff[PAD_BITS-1:OUT_MANT_BITS];
   assign round_up = (rem_ff > HALF_DIGIT) ||
                     ((rem_ff == HALF_DIGIT) && (sticky_ff || mant_ff[0]));

   assign status.loop_cond = (upper_nz && (scale_ff != 8'd0)) || (scale_ff > 8'(MAX_SCALE));
   assign status.out_full  = out_valid_ff;

   always_comb begin
      in_ext       = EXT_BITS'(req_tdata[IN_MANT_BITS-1:0]);
      mant_in      = mant_ff;
      scale_in     = scale_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      prem_in      = prem_ff;
      sticky_in    = sticky_ff;
      divided_in   = divided_ff;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_valid_in = out_valid_ff;

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.load) begin
         mant_in    = in_ext[PAD_BITS-1:0] & WIDE_MASK;
         scale_in   = req_tdata[IN_MANT_BITS +: 8];
         neg_in     = req_tdata[IN_MANT_BITS + 8];
         rem_in     = 4'd0;
         sticky_in  = 1'b0;
         divided_in = 1'b0;
      end

      if (cmd.div_start) begin
         sticky_in = sticky_ff | (divided_ff && (rem_ff != 4'd0));
         prem_in   = 4'd0;
      end

      if (cmd.div_step) begin
         mant_in = {mant_ff[PAD_BITS-LIMB_BITS-1:0], q};
         prem_in = r[3:0];
      end

      if (cmd.div_last) begin
         rem_in     = r[3:0];
         scale_in   = scale_ff - 8'd1;
         divided_in = 1'b1;
      end

      if (cmd.round) begin
         mant_in = mant_ff + PAD_BITS'(round_up);
      end

      if (cmd.publish) begin
         out_valid_in = 1'b1;
         if (upper_nz) begin
            out_data_in = RSP_DATA_BITS'({neg_ff, 5'd0, {OUT_MANT_BITS{1'b0}}});
            out_user_in = neg_ff ? CLASS_NEG_INF : CLASS_POS_INF;
         end else begin
            out_data_in = RSP_DATA_BITS'({neg_ff, scale_ff[4:0],
                                          mant_ff[OUT_MANT_BITS-1:0]});
            out_user_in = CLASS_NORMAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      mant_ff     <= mant_in;
      scale_ff    <= scale_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      prem_ff     <= prem_in;
      sticky_ff   <= sticky_in;
      divided_ff  <= divided_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// ===== rtl/core/wdnr_ctrl.sv =====
module wdnr_ctrl
   import wdnr_pkg::*;
#(
   parameter int WIDE_BITS = WIDE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int LIMBS  = (WIDE_BITS + LIMB_BITS - 1) / LIMB_BITS;
   localparam int CNT_W  = $clog2(LIMBS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_ROUND  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.loop_cond) begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = S_DIV;
            end else begin
               state_in = S_ROUND;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(LIMBS - 1)) begin
               cmd.div_last = 1'b1;
               state_in     = S_CHECK;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            // hold until the response register is free or drains this cycle
            if (!status.out_full || rsp_tready) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/wide_decimal_normalize_round_top.sv =====
// Per request: load, then D divisions by ten over L = ceil(WIDE_BITS / 32) limbs
//   (6 at the default), then rounding and the response beat.
// Throughput: one item at a time; the next request beat is taken only after the
//   previous result lands in the response register, which may still be waiting.
// Each division by ten walks the mantissa one 32-bit limb per cycle through one divider.
// Reset: synchronous, active high; clears the sequencer and the response valid flag.
module wide_decimal_normalize_round_top
   import wdnr_pkg::*;
#(
   parameter int WIDE_BITS = WIDE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // request beat
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [63:0] mant_w0, [127:64] mant_w1, [191:128] mant_w2, [199:192] in_scale,
   // [200] in_negative, [207:201] zero
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // response beat
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [63:0] out_low, [95:64] out_high, [100:96] out_scale, [101] out_negative,
   // [103:102] zero
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // [1:0] out_class
   output logic [RSP_USER_BITS-1:0] rsp_tuser
);

   cmd_type    cmd;
   status_type status;

   // Sequencer: load, repeat check/divide until the scale and width fit (or no scale
   // is left), round half to even, and hand the result to the response register.
   wdnr_ctrl #(
      .WIDE_BITS (WIDE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Mantissa rotator with the limb divider, rounding adder and response register.
   wdnr_datapath #(
      .WIDE_BITS (WIDE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/core/wdnr_checker.sv =====
module wdnr_checker
   import wdnr_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [RSP_USER_BITS-1:0] rsp_tuser
);

   // one item at a time: ready drops right after a request beat is taken
   a_req_once: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request ready stayed high after a taken beat");

   // an infinity carries a zero mantissa and scale
   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != CLASS_NORMAL)) |-> (rsp_tdata[100:0] == 101'd0))
      else $error("infinity beat with nonzero mantissa or scale");

   // infinity class follows the sign bit
   a_inf_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != CLASS_NORMAL)) |->
      (rsp_tuser == (rsp_tdata[101] ? CLASS_NEG_INF : CLASS_POS_INF)))
      else $error("infinity class disagrees with sign");

   // a normal result never leaves the scale above the limit
   a_scale_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == CLASS_NORMAL)) |-> (rsp_tdata[100:96] <= 5'(MAX_SCALE)))
      else $error("normal beat with scale above limit");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
      (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response beat changed");

endmodule

bind wide_decimal_normalize_round_top wdnr_checker u_wdnr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/rescale_round_checker.sv =====
module rescale_round_checker
   import wdnr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   // [191:0] mantissa, [199:192] in_scale, [200] in_negative, [207:201] zero
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [63:0] out_low, [95:64] out_high, [100:96] out_scale, [101] out_negative,
   // [103:102] zero
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // [1:0] out_class
   input  logic [RSP_USER_BITS-1:0] rsp_tuser,
   output int unsigned              rescaled_pending,
   output int unsigned              fail_count,
   output int unsigned              results_checked,
   output int unsigned              infinities_seen,
   output int unsigned              round_ups_seen,
   output int unsigned              half_digits_seen
);

   typedef struct packed {
      logic [63:0] low;
      logic [31:0] high;
      logic [4:0]  scale;
      logic        negative;
      logic [1:0]  cls;
   } rescaled_type;

   rescaled_type pending_rescaled[$];

   initial begin
      rescaled_pending = 0;
      fail_count       = 0;
      results_checked  = 0;
      infinities_seen  = 0;
      round_ups_seen   = 0;
      half_digits_seen = 0;
   end

   // Divide by ten until the mantissa fits (or the scale is zero) and the scale is legal,
   // then round half to even; a sticky flag keeps any nonzero digit dropped before the last.
   function automatic rescaled_type rescale_round(input logic [IN_MANT_BITS-1:0] mant,
                                                  input logic [7:0] scale_in,
                                                  input logic negative,
                                                  output bit rounded,
                                                  output bit half_digit);
      logic [IN_MANT_BITS-1:0] m;
      logic [7:0]              sc;
      logic [3:0]              last_digit;
      bit                      sticky;
      bit                      divided;
      rescaled_type            r;
      m          = mant;
      sc         = scale_in;
      last_digit = '0;
      sticky     = 1'b0;
      divided    = 1'b0;
      while ((m[IN_MANT_BITS-1:OUT_MANT_BITS] != '0 && sc != 8'd0) || sc > MAX_SCALE) begin
         if (divided && last_digit != 4'd0) sticky = 1'b1;
         last_digit = 4'(m % IN_MANT_BITS'(TEN));
         m          = m / IN_MANT_BITS'(TEN);
         divided    = 1'b1;
         sc         = sc - 8'd1;
      end
      half_digit = (last_digit == HALF_DIGIT);
      rounded    = (last_digit > HALF_DIGIT) ||
                   (last_digit == HALF_DIGIT && (sticky || m[0]));
      if (rounded) m = m + 1'b1;
      r.negative = negative;
      if (m[IN_MANT_BITS-1:OUT_MANT_BITS] != '0) begin
         r.low   = '0;
         r.high  = '0;
         r.scale = '0;
         r.cls   = negative ? CLASS_NEG_INF : CLASS_POS_INF;
      end else begin
         r.low   = m[63:0];
         r.high  = m[95:64];
         r.scale = sc[4:0];
         r.cls   = CLASS_NORMAL;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count = fail_count + 1;
      if (fail_count <= 100)
         $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      rescaled_type want;
      rescaled_type got;
      bit           rounded;
      bit           half_digit;
      if (!reset) begin
         // Predict on every request beat and queue the result.
         if (req_tvalid && req_tready) begin
            want = rescale_round(req_tdata[191:0], req_tdata[199:192], req_tdata[200],
                                 rounded, half_digit);
            pending_rescaled.push_back(want);
            if (rounded) round_ups_seen = round_ups_seen + 1;
            if (half_digit) half_digits_seen = half_digits_seen + 1;
         end
         // Compare every response beat with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            got.low      = rsp_tdata[63:0];
            got.high     = rsp_tdata[95:64];
            got.scale    = rsp_tdata[100:96];
            got.negative = rsp_tdata[101];
            got.cls      = rsp_tuser[1:0];
            if (pending_rescaled.size() == 0) begin
               report_mismatch("response beat with nothing queued", rsp_tdata[63:0], '0);
            end else begin
               want = pending_rescaled.pop_front();
               results_checked = results_checked + 1;
               if (got.cls != CLASS_NORMAL) infinities_seen = infinities_seen + 1;
               if (got.low != want.low) report_mismatch("out_low", got.low, want.low);
               if (got.high != want.high) report_mismatch("out_high", got.high, want.high);
               if (got.scale != want.scale)
                  report_mismatch("out_scale", got.scale, want.scale);
               if (got.negative != want.negative)
                  report_mismatch("out_negative", got.negative, want.negative);
               if (got.cls != want.cls) report_mismatch("out_class", got.cls, want.cls);
            end
         end
      end
      rescaled_pending <= pending_rescaled.size();
   end

endmodule

// ===== tb/tb.sv =====
module tb
   import wdnr_pkg::*;
();

   localparam int RANDOM_ITEMS = 1750;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   // [191:0] mantissa, [199:192] in_scale, [200] in_negative, [207:201] zero
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [63:0] out_low, [95:64] out_high, [100:96] out_scale, [101] out_negative,
   // [103:102] zero
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   // [1:0] out_class
   logic [RSP_USER_BITS-1:0] rsp_tuser;

   int unsigned rescaled_pending;
   int unsigned fail_count;
   int unsigned results_checked;
   int unsigned infinities_seen;
   int unsigned round_ups_seen;
   int unsigned half_digits_seen;
   int unsigned requests_sent = 0;
   int unsigned stall_left = 0;
   bit          no_idle = 1'b0;

   wide_decimal_normalize_round_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rescale_round_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rescaled_pending (rescaled_pending),
      .fail_count       (fail_count),
      .results_checked  (results_checked),
      .infinities_seen  (infinities_seen),
      .round_ups_seen   (round_ups_seen),
      .half_digits_seen (half_digits_seen)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Idle length: mostly none or a short one, now and then a long one; none at all
   // while a no-idle stretch is running.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Response side: hold ready low for random stalls that start on any cycle, so
   // stalls land both while the block is dividing and while a result waits.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!no_idle && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   // Present one request beat after a random gap and hold it until taken. Returns at
   // the accepting edge, so the next call may either drop valid or replace the beat.
   task automatic send_req(input logic [191:0] mant, input logic [7:0] sc,
                           input logic negative);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, negative, sc, mant};
      do @(posedge clock); while (!req_tready);
      requests_sent = requests_sent + 1;
   endtask

   initial begin
      logic [191:0] all_ones;
      logic [191:0] top96;
      logic [191:0] mant;
      logic [191:0] mask;
      logic [7:0]   sc;
      logic [6:0]   tail;
      int unsigned  width_bits;
      int unsigned  r;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      all_ones   = '1;
      top96      = 192'd1 << 96;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, the no-division path, the scale cap, and each
      // rounding case around the 96-bit boundary.
      send_req('0, 8'd0, 1'b0);
      send_req(all_ones, 8'd0, 1'b0);               // too wide, no room to divide
      send_req(all_ones, 8'd0, 1'b1);
      send_req(all_ones, 8'd255, 1'b1);             // longest division chain
      send_req(all_ones, 8'd28, 1'b0);
      send_req(top96 - 1, 8'd0, 1'b0);              // largest value that fits
      send_req(top96, 8'd0, 1'b0);
      send_req(top96, 8'd1, 1'b0);                  // last digit above half
      send_req(192'd123, 8'd29, 1'b0);              // scale above the cap
      send_req(192'd25, 8'd29, 1'b0);               // half, even quotient stays
      send_req(192'd35, 8'd29, 1'b1);               // half, odd quotient goes up
      send_req(192'd251, 8'd30, 1'b0);              // half with an earlier dropped digit
      send_req('0, 8'd255, 1'b0);
      send_req((top96 - 2) * 10 + 5, 8'd1, 1'b0);
      send_req((top96 - 3) * 10 + 5, 8'd1, 1'b0);
      send_req((top96 - 1) * 10 + 5, 8'd1, 1'b1);   // rounding carries out of range
      send_req((top96 - 1) * 10 + 5, 8'd1, 1'b0);
      send_req(((top96 - 2) * 10 + 5) * 10 + 3, 8'd2, 1'b0);
      send_req(((top96 - 2) * 10 + 5) * 10, 8'd2, 1'b0);
      send_req((top96 - 2) * 10 + 5, 8'd0, 1'b0);
      send_req({96'h0, {24{4'hA}}}, 8'd200, 1'b1);
      send_req({24{8'h55}}, 8'd147, 1'b0);

      // Random: mostly values just above 96 bits with small scales, so a handful of
      // divisions is needed; some short values, a few very large scales, and a good
      // share of low decimal digits forced onto the half-way point.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
         mant = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
         r = $urandom_range(0, 99);
         if (r < 15) width_bits = $urandom_range(0, 96);
         else if (r < 70) width_bits = $urandom_range(97, 140);
         else width_bits = $urandom_range(141, 192);
         mask = all_ones >> (192 - width_bits);
         mant = mant & mask;
         if ($urandom_range(0, 9) < 4) begin
            case ($urandom_range(0, 6))
               0: tail = 7'd50;
               1: tail = 7'd5;
               2: tail = 7'd55;
               3: tail = 7'd45;
               4: tail = 7'd51;
               5: tail = 7'd95;
               default: tail = 7'd0;
            endcase
            mant = mant - (mant % 192'd100) + tail;
         end
         r = $urandom_range(0, 99);
         if (r < 88) sc = 8'($urandom_range(0, 30));
         else if (r < 97) sc = 8'($urandom_range(31, 60));
         else sc = 8'($urandom_range(61, 255));
         send_req(mant, sc, 1'($urandom()));
      end
      req_tvalid <= 1'b0;
      no_idle = 1'b0;

      // Drain: wait for every queued prediction to be answered, then a short tail.
      do @(posedge clock); while (rescaled_pending != 0);
      repeat (16) @(posedge clock);

      $display("sent %0d requests, checked %0d results: %0d infinities, %0d rounded up,",
               requests_sent, results_checked, infinities_seen, round_ups_seen);
      $display("%0d with a half-way last digit; %0d mismatches", half_digits_seen,
               fail_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, every item at full scale.
   initial begin
      #300_000_000;
      $display("watchdog expired with %0d results outstanding", rescaled_pending);
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/wdnr_pkg.sv
rtl/core/wdnr_datapath.sv
rtl/core/wdnr_ctrl.sv
rtl/core/wide_decimal_normalize_round_top.sv
rtl/core/wdnr_checker.sv
tb/rescale_round_checker.sv
tb/tb.sv
